/* src/jtm_pkg.sv */
package jtm_pkg;

  localparam int Q_BITS = 16;
  localparam int DIV_LANES = 2;

  localparam logic signed [15:0] COS45_Q15 = 16'sd23170;
  localparam logic [16:0] ONE_Q15 = 17'd32768;

  localparam logic [14:0] THRESHOLD_RESET = 15'd3277;
  localparam logic [14:0] GAIN_RESET = 15'd22938;
  localparam logic [15:0] DELAY_RESET = 16'd500;
  localparam logic [14:0] EPSILON_RESET = 15'd33;

  localparam logic KIND_POWER = 1'b0;
  localparam logic KIND_LED = 1'b1;

  localparam logic [1:0] SERVO_ZERO = 2'd0;
  localparam logic [1:0] SERVO_PLUS = 2'd1;
  localparam logic [1:0] SERVO_MINUS = 2'd2;

  localparam logic [1:0] MOTION_NONE = 2'd0;
  localparam logic [1:0] MOTION_STOPPED = 2'd1;
  localparam logic [1:0] MOTION_MOVING = 2'd2;

  localparam logic [1:0] BOARD_SUSPEND = 2'd0;
  localparam logic [1:0] BOARD_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    CMD_JOY    = 2'd0,
    CMD_BOARD  = 2'd1,
    CMD_HEALTH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_GAIN      = 2'd1,
    CFG_DELAY     = 2'd2,
    CFG_EPSILON   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PATH_MIX,
    PATH_STOP,
    PATH_ROT,
    PATH_VERT
  } path_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_ROUND,
    ST_NORM,
    ST_DIV,
    ST_FORM,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic round_b;
    logic norm;
    logic div_step;
    logic form;
    logic emit;
  } jtm_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } jtm_stat_t;

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return e[16] ? 17'(-e) : 17'(e);
  endfunction

  function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
    return (v == -16'sd32768) ? 16'sd32767 : 16'(-v);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [17:0] round_q30(input logic signed [32:0] p);
    logic [32:0] m;
    logic [32:0] s;
    logic signed [17:0] r;
    m = p[32] ? 33'(-p) : 33'(p);
    s = m + 33'd16384;
    r = $signed({1'b0, s[31:15]});
    return p[32] ? 18'(-r) : r;
  endfunction

endpackage

/* src/jtm_div.sv */
module jtm_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                step,
  input  logic [15:0]         divisor,
  input  logic [1:0][31:0]    num,
  output logic [1:0][15:0]    quo,
  output logic                last
);
  import jtm_pkg::*;

  localparam int CNT_W = $clog2(Q_BITS);

  logic [CNT_W-1:0]            cnt;
  logic [DIV_LANES-1:0][15:0]  rem;
  logic [DIV_LANES-1:0][15:0]  acc;
  logic [DIV_LANES-1:0][15:0]  rem_next;
  logic [DIV_LANES-1:0][15:0]  acc_next;

  always_comb begin
    logic [16:0] trial;
    logic        ge;
    for (int i = 0; i < DIV_LANES; i++) begin
      trial = {rem[i], acc[i][15]};
      ge = trial >= {1'b0, divisor};
      rem_next[i] = ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      acc_next[i] = {acc[i][14:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_LANES; i++) begin
      if (load) begin
        rem[i] <= num[i][31:16];
        acc[i] <= num[i][15:0];
      end else if (step) begin
        rem[i] <= rem_next[i];
        acc[i] <= acc_next[i];
      end
    end
  end

  assign quo = acc;
  assign last = (cnt == CNT_W'(Q_BITS - 1));

endmodule

/* src/jtm_dp.sv */
module jtm_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  jtm_pkg::jtm_cmd_t     ctl,
  output jtm_pkg::jtm_stat_t    stat,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [1:0]            cmd,
  input  logic signed [15:0]    left_horizontal,
  input  logic signed [15:0]    left_vertical_raw,
  input  logic signed [15:0]    right_horizontal,
  input  logic signed [15:0]    right_vertical_raw,
  input  logic                  button_west,
  input  logic                  button_south,
  input  logic [31:0]           time_ms,
  input  logic [1:0]            board_state_in,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  result_kind,
  output logic signed [15:0]    thruster_a,
  output logic signed [15:0]    thruster_b,
  output logic signed [15:0]    thruster_c,
  output logic signed [15:0]    thruster_d,
  output logic [1:0]            servo_code,
  output logic                  order_initialize,
  output logic                  order_suspend,
  output logic [1:0]            led_left,
  output logic [1:0]            led_right
);
  import jtm_pkg::*;

  logic [14:0] stick_threshold;
  logic [14:0] rotate_gain;
  logic [15:0] vertical_delay_ms;
  logic [14:0] zero_epsilon;

  logic [1:0]  motion_status;
  logic [1:0]  board_state;
  logic        vertical_active;
  logic [31:0] vertical_start_time;

  logic signed [15:0] lh;
  logic signed [15:0] lv;
  logic signed [15:0] rh;
  logic signed [15:0] rv;
  logic               bw;
  logic               bs;
  logic [31:0]        now;
  logic               is_led;

  logic signed [32:0] prod;
  logic signed [17:0] b1;
  logic signed [17:0] b2;
  logic               norm;
  logic               vert_go;
  logic signed [15:0] t_a;
  logic signed [15:0] t_b;
  logic signed [15:0] t_c;
  logic signed [15:0] t_d;
  logic [1:0]         servo;

  path_t              path;
  logic signed [16:0] mul_x;
  logic signed [15:0] mul_y;
  logic [16:0]        m1;
  logic [16:0]        m2;
  logic [16:0]        m;
  logic [1:0][31:0]   div_num;
  logic [1:0][15:0]   quo;
  logic               div_last;
  logic [31:0]        held;
  logic               all_zero;
  logic signed [15:0] mix1;
  logic signed [15:0] mix2;
  logic signed [15:0] rot_mag;
  logic signed [15:0] rot_p;
  logic signed [15:0] vert_mag;

  always_comb begin
    logic lh_on;
    logic lv_on;
    logic rh_on;
    logic rv_on;
    lh_on = abs16(lh) > {2'b0, stick_threshold};
    lv_on = abs16(lv) > {2'b0, stick_threshold};
    rh_on = abs16(rh) > {2'b0, stick_threshold};
    rv_on = abs16(rv) > {2'b0, stick_threshold};
    if (lh_on || lv_on) begin
      path = PATH_MIX;
    end else if (!(rh_on || rv_on)) begin
      path = PATH_STOP;
    end else if (rh_on) begin
      path = PATH_ROT;
    end else begin
      path = PATH_VERT;
    end
  end

  always_comb begin
    if (ctl.mul_b) begin
      mul_x = 17'({lv[15], lv} - {lh[15], lh});
      mul_y = COS45_Q15;
    end else if (path == PATH_MIX) begin
      mul_x = 17'({lv[15], lv} + {lh[15], lh});
      mul_y = COS45_Q15;
    end else begin
      mul_x = $signed(abs16(rh));
      mul_y = $signed({1'b0, rotate_gain});
    end
  end

  assign m1 = b1[17] ? 17'(-b1) : 17'(b1);
  assign m2 = b2[17] ? 17'(-b2) : 17'(b2);
  assign m = (m1 > m2) ? m1 : m2;
  assign div_num[0] = 32'({m1, 15'b0}) + 32'(m[16:1]);
  assign div_num[1] = 32'({m2, 15'b0}) + 32'(m[16:1]);

  jtm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .load    (ctl.norm),
    .step    (ctl.div_step),
    .divisor (m[15:0]),
    .num     (div_num),
    .quo     (quo),
    .last    (div_last)
  );

  assign held = vertical_active ? (now - vertical_start_time) : 32'd0;

  always_comb begin
    if (norm) begin
      mix1 = sat16(b1[17] ? 18'(-$signed({2'b0, quo[0]})) : $signed({2'b0, quo[0]}));
      mix2 = sat16(b2[17] ? 18'(-$signed({2'b0, quo[1]})) : $signed({2'b0, quo[1]}));
    end else begin
      mix1 = sat16(b1);
      mix2 = sat16(b2);
    end
    rot_mag = sat16(b1);
    rot_p = rh[15] ? 16'(-rot_mag) : rot_mag;
    vert_mag = vert_go ? sat16($signed({1'b0, abs16(rv)})) : 16'sd0;
  end

  assign all_zero = (abs16(t_a) <= {2'b0, zero_epsilon}) &&
                    (abs16(t_b) <= {2'b0, zero_epsilon}) &&
                    (abs16(t_c) <= {2'b0, zero_epsilon}) &&
                    (abs16(t_d) <= {2'b0, zero_epsilon});

  assign stat.need_div = (path == PATH_MIX) && (m > ONE_Q15);
  assign stat.div_last = div_last;
  assign stat.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lh <= left_horizontal;
      lv <= neg_sat16(left_vertical_raw);
      rh <= right_horizontal;
      rv <= neg_sat16(right_vertical_raw);
      bw <= button_west;
      bs <= button_south;
      now <= time_ms;
      is_led <= (cmd_t'(cmd) == CMD_HEALTH);
    end
    if (ctl.mul_a || ctl.mul_b) begin
      prod <= mul_x * mul_y;
    end
    if (ctl.mul_a) begin
      vert_go <= held > {16'b0, vertical_delay_ms};
    end
    if (ctl.mul_b) begin
      b1 <= round_q30(prod);
    end
    if (ctl.round_b) begin
      b2 <= round_q30(prod);
    end
    if (ctl.norm) begin
      norm <= stat.need_div;
    end
    if (ctl.form) begin
      servo <= SERVO_ZERO;
      unique case (path)
        PATH_MIX: begin
          t_a <= mix1;
          t_b <= mix2;
          t_c <= mix2;
          t_d <= mix1;
        end
        PATH_ROT: begin
          t_a <= rot_p;
          t_b <= 16'(-rot_p);
          t_c <= rot_p;
          t_d <= 16'(-rot_p);
        end
        PATH_VERT: begin
          t_a <= vert_mag;
          t_b <= vert_mag;
          t_c <= vert_mag;
          t_d <= vert_mag;
          servo <= rv[15] ? SERVO_MINUS : SERVO_PLUS;
        end
        default: begin
          t_a <= '0;
          t_b <= '0;
          t_c <= '0;
          t_d <= '0;
        end
      endcase
    end
    if (ctl.emit) begin
      if (is_led) begin
        result_kind <= KIND_LED;
        thruster_a <= '0;
        thruster_b <= '0;
        thruster_c <= '0;
        thruster_d <= '0;
        servo_code <= SERVO_ZERO;
        order_initialize <= 1'b0;
        order_suspend <= 1'b0;
        led_left <= board_state;
        led_right <= motion_status;
      end else begin
        result_kind <= KIND_POWER;
        thruster_a <= t_a;
        thruster_b <= t_b;
        thruster_c <= t_c;
        thruster_d <= t_d;
        servo_code <= servo;
        order_initialize <= bw;
        order_suspend <= !bw && bs;
        led_left <= 2'd0;
        led_right <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_threshold <= THRESHOLD_RESET;
      rotate_gain <= GAIN_RESET;
      vertical_delay_ms <= DELAY_RESET;
      zero_epsilon <= EPSILON_RESET;
      motion_status <= MOTION_NONE;
      board_state <= BOARD_SUSPEND;
      vertical_active <= 1'b0;
      vertical_start_time <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD: stick_threshold <= cfg_data[14:0];
          CFG_GAIN:      rotate_gain <= cfg_data[14:0];
          CFG_DELAY:     vertical_delay_ms <= cfg_data;
          CFG_EPSILON:   zero_epsilon <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (ctl.load && cmd_t'(cmd) == CMD_BOARD && board_state_in != BOARD_RESERVED) begin
        board_state <= board_state_in;
      end
      if (ctl.emit) begin
        result_valid <= 1'b1;
        if (is_led) begin
          motion_status <= MOTION_NONE;
        end else begin
          motion_status <= all_zero ? MOTION_STOPPED : MOTION_MOVING;
          vertical_active <= (path == PATH_VERT);
          if (path == PATH_VERT && !vertical_active) begin
            vertical_start_time <= now;
          end
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/jtm_ctrl.sv */
module jtm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [1:0]          cmd,
  input  jtm_pkg::jtm_stat_t  stat,
  output jtm_pkg::jtm_cmd_t   ctl
);
  import jtm_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          unique case (cmd_t'(cmd)) inside
            CMD_JOY:             state_next = ST_MUL_A;
            CMD_HEALTH:          state_next = ST_EMIT;
            CMD_BOARD, CMD_NONE: state_next = ST_IDLE;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_ROUND;
      ST_ROUND: state_next = ST_NORM;
      ST_NORM:  state_next = stat.need_div ? ST_DIV : ST_FORM;
      ST_DIV: begin
        if (stat.div_last) begin
          state_next = ST_FORM;
        end
      end
      ST_FORM: state_next = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    sample_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        ctl.load = sample_valid;
      end
      ST_MUL_A: ctl.mul_a = 1'b1;
      ST_MUL_B: ctl.mul_b = 1'b1;
      ST_ROUND: ctl.round_b = 1'b1;
      ST_NORM:  ctl.norm = 1'b1;
      ST_DIV:   ctl.div_step = 1'b1;
      ST_FORM:  ctl.form = 1'b1;
      ST_EMIT:  ctl.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* src/joystick_thruster_mixer.sv */
// A joystick sample, once accepted, steps through MUL_A, MUL_B, ROUND and NORM, then the
// 16-step two-lane divider (DIV) if the left-stick mix is renormalised, then FORM and EMIT,
// which registers the result once the output is free. A new item is accepted in the cycle
// after the previous result has been registered; a health tick goes straight to EMIT.
// Synchronous reset returns the controller to idle, empties the result register and loads the
// configuration and status registers with their defaults.
module joystick_thruster_mixer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] left_horizontal,
  input  logic signed [15:0] left_vertical_raw,
  input  logic signed [15:0] right_horizontal,
  input  logic signed [15:0] right_vertical_raw,
  input  logic               button_west,
  input  logic               button_south,
  input  logic [31:0]        time_ms,
  input  logic [1:0]         board_state_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               result_kind,
  output logic signed [15:0] thruster_a,
  output logic signed [15:0] thruster_b,
  output logic signed [15:0] thruster_c,
  output logic signed [15:0] thruster_d,
  output logic [1:0]         servo_code,
  output logic               order_initialize,
  output logic               order_suspend,
  output logic [1:0]         led_left,
  output logic [1:0]         led_right
);
  import jtm_pkg::*;

  jtm_cmd_t  ctl;
  jtm_stat_t stat;

  jtm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cmd          (cmd),
    .stat         (stat),
    .ctl          (ctl)
  );

  jtm_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .left_horizontal    (left_horizontal),
    .left_vertical_raw  (left_vertical_raw),
    .right_horizontal   (right_horizontal),
    .right_vertical_raw (right_vertical_raw),
    .button_west        (button_west),
    .button_south       (button_south),
    .time_ms            (time_ms),
    .board_state_in     (board_state_in),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .result_kind        (result_kind),
    .thruster_a         (thruster_a),
    .thruster_b         (thruster_b),
    .thruster_c         (thruster_c),
    .thruster_d         (thruster_d),
    .servo_code         (servo_code),
    .order_initialize   (order_initialize),
    .order_suspend      (order_suspend),
    .led_left           (led_left),
    .led_right          (led_right)
  );

endmodule

/* src/jtm_checker.sv */
module jtm_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_we,
  input logic [1:0]         cfg_index,
  input logic [15:0]        cfg_data,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic [1:0]         cmd,
  input logic signed [15:0] left_horizontal,
  input logic signed [15:0] left_vertical_raw,
  input logic signed [15:0] right_horizontal,
  input logic signed [15:0] right_vertical_raw,
  input logic               button_west,
  input logic               button_south,
  input logic [31:0]        time_ms,
  input logic [1:0]         board_state_in,
  input logic               result_valid,
  input logic               result_stall,
  input logic               result_kind,
  input logic signed [15:0] thruster_a,
  input logic signed [15:0] thruster_b,
  input logic signed [15:0] thruster_c,
  input logic signed [15:0] thruster_d,
  input logic [1:0]         servo_code,
  input logic               order_initialize,
  input logic               order_suspend,
  input logic [1:0]         led_left,
  input logic [1:0]         led_right
);
  import jtm_pkg::*;

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_kind) && $stable(thruster_a) &&
      $stable(thruster_b) && $stable(thruster_c) && $stable(thruster_d) &&
      $stable(servo_code) && $stable(order_initialize) && $stable(order_suspend) &&
      $stable(led_left) && $stable(led_right))
    else $error("result beat changed while stalled");

  a_led_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_LED |-> thruster_a == 16'sd0 &&
      thruster_b == 16'sd0 && thruster_c == 16'sd0 && thruster_d == 16'sd0 &&
      servo_code == SERVO_ZERO && !order_initialize && !order_suspend &&
      led_left != 2'd3 && led_right != 2'd3)
    else $error("LED beat carries power fields or an invalid colour");

  a_power_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_POWER |-> led_left == 2'd0 && led_right == 2'd0 &&
      !(order_initialize && order_suspend) && servo_code != 2'd3)
    else $error("power beat carries LED fields, both orders or an invalid servo code");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind joystick_thruster_mixer jtm_checker u_checker (.*);

/* tb/tb_joystick_thruster_mixer.sv */
module tb_joystick_thruster_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  import jtm_pkg::*;

  localparam logic [1:0] BOARD_INIT = 2'd1;
  localparam logic [1:0] BOARD_RUN = 2'd2;

  typedef enum int {
    DRIVE_MIX,
    DRIVE_TURN,
    DRIVE_RISE,
    DRIVE_REST,
    DRIVE_ANY
  } drive_kind_t;

  typedef struct {
    cmd_t               cmd;
    logic signed [15:0] lh;
    logic signed [15:0] lvr;
    logic signed [15:0] rh;
    logic signed [15:0] rvr;
    logic               west;
    logic               south;
    logic [31:0]        ms;
    logic [1:0]         board_in;
    bit                 drain;
    int                 gap;
  } stick_beat_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] pa;
    logic signed [15:0] pb;
    logic signed [15:0] pc;
    logic signed [15:0] pd;
    logic [1:0]         servo;
    logic               init_order;
    logic               suspend_order;
    logic [1:0]         led_l;
    logic [1:0]         led_r;
  } mixer_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_THRESHOLD;
  logic [15:0]        cfg_data = '0;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  logic [1:0]         cmd = CMD_NONE;
  logic signed [15:0] left_horizontal = '0;
  logic signed [15:0] left_vertical_raw = '0;
  logic signed [15:0] right_horizontal = '0;
  logic signed [15:0] right_vertical_raw = '0;
  logic               button_west = 1'b0;
  logic               button_south = 1'b0;
  logic [31:0]        time_ms = '0;
  logic [1:0]         board_state_in = BOARD_SUSPEND;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               result_kind;
  logic signed [15:0] thruster_a;
  logic signed [15:0] thruster_b;
  logic signed [15:0] thruster_c;
  logic signed [15:0] thruster_d;
  logic [1:0]         servo_code;
  logic               order_initialize;
  logic               order_suspend;
  logic [1:0]         led_left;
  logic [1:0]         led_right;

  longint     thr_reg = THRESHOLD_RESET;
  longint     gain_reg = GAIN_RESET;
  longint     delay_reg = DELAY_RESET;
  longint     eps_reg = EPSILON_RESET;
  logic [1:0] motion_now = MOTION_NONE;
  logic [1:0] board_now = BOARD_SUSPEND;
  bit         vert_on = 1'b0;
  logic [31:0] vert_t0 = '0;

  stick_beat_t pending[$];
  mixer_out_t  due[$];
  stick_beat_t cur;
  int          samples_sent = 0;
  int          samples_taken = 0;
  int          outputs_taken = 0;
  int          outputs_seen = 0;
  int          errors = 0;
  int          beats_made = 0;
  int          gap_left = 0;
  bit          gap_armed = 1'b0;
  int          stall_left = 5;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  logic [31:0] ms_now = '0;

  always #1 clk = ~clk;

  joystick_thruster_mixer i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .sample_valid       (sample_valid),
    .sample_stall       (sample_stall),
    .cmd                (cmd),
    .left_horizontal    (left_horizontal),
    .left_vertical_raw  (left_vertical_raw),
    .right_horizontal   (right_horizontal),
    .right_vertical_raw (right_vertical_raw),
    .button_west        (button_west),
    .button_south       (button_south),
    .time_ms            (time_ms),
    .board_state_in     (board_state_in),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .result_kind        (result_kind),
    .thruster_a         (thruster_a),
    .thruster_b         (thruster_b),
    .thruster_c         (thruster_c),
    .thruster_d         (thruster_d),
    .servo_code         (servo_code),
    .order_initialize   (order_initialize),
    .order_suspend      (order_suspend),
    .led_left           (led_left),
    .led_right          (led_right)
  );

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint q30_to_q15(longint p);
    longint r;
    r = (mag(p) + 16384) >>> 15;
    return p < 0 ? -r : r;
  endfunction

  function automatic longint flip_axis(logic signed [15:0] raw);
    return clamp16(-longint'(raw));
  endfunction

  function automatic bit predict_mixer_output(input stick_beat_t b, output mixer_out_t o);
    longint lh, lv, rh, rv, b1, b2, m, mg, p, one;
    longint pw[4];
    logic [31:0] held;
    bit lively;
    o = '0;
    one = ONE_Q15;
    case (b.cmd)
      CMD_BOARD: begin
        if (b.board_in != BOARD_RESERVED) board_now = b.board_in;
        return 1'b0;
      end
      CMD_HEALTH: begin
        o.kind = KIND_LED;
        o.led_l = board_now;
        o.led_r = motion_now;
        motion_now = MOTION_NONE;
        return 1'b1;
      end
      CMD_JOY: ;
      default: return 1'b0;
    endcase
    lh = b.lh;
    lv = flip_axis(b.lvr);
    rh = b.rh;
    rv = flip_axis(b.rvr);
    pw = '{0, 0, 0, 0};
    o.kind = KIND_POWER;
    o.init_order = b.west;
    o.suspend_order = !b.west && b.south;
    o.servo = SERVO_ZERO;
    if (mag(lh) > thr_reg || mag(lv) > thr_reg) begin
      b1 = q30_to_q15((lv + lh) * longint'(COS45_Q15));
      b2 = q30_to_q15((lv - lh) * longint'(COS45_Q15));
      m = mag(b1) > mag(b2) ? mag(b1) : mag(b2);
      if (m > one) begin
        p = (mag(b1) * one + m / 2) / m;
        b1 = b1 < 0 ? -p : p;
        p = (mag(b2) * one + m / 2) / m;
        b2 = b2 < 0 ? -p : p;
      end
      pw = '{clamp16(b1), clamp16(b2), clamp16(b2), clamp16(b1)};
      vert_on = 1'b0;
    end else if (mag(rh) <= thr_reg && mag(rv) <= thr_reg) begin
      vert_on = 1'b0;
    end else if (mag(rh) > thr_reg) begin
      mg = clamp16(q30_to_q15(mag(rh) * gain_reg));
      p = rh < 0 ? -mg : mg;
      pw = '{p, -p, p, -p};
      vert_on = 1'b0;
    end else begin
      if (!vert_on) begin
        vert_on = 1'b1;
        vert_t0 = b.ms;
      end
      held = b.ms - vert_t0;
      mg = held > delay_reg ? clamp16(mag(rv)) : 0;
      pw = '{mg, mg, mg, mg};
      o.servo = rv < 0 ? SERVO_MINUS : SERVO_PLUS;
    end
    lively = 1'b0;
    foreach (pw[k]) begin
      if (mag(pw[k]) > eps_reg) lively = 1'b1;
    end
    motion_now = lively ? MOTION_MOVING : MOTION_STOPPED;
    o.pa = pw[0];
    o.pb = pw[1];
    o.pc = pw[2];
    o.pd = pw[3];
    return 1'b1;
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      errors++;
      if (errors <= 100) begin
        $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      end
    end
  endfunction

  function automatic stick_beat_t blank_beat(cmd_t c);
    stick_beat_t b;
    b.cmd = c;
    b.lh = '0;
    b.lvr = '0;
    b.rh = '0;
    b.rvr = '0;
    b.west = 1'b0;
    b.south = 1'b0;
    b.ms = ms_now;
    b.board_in = 2'($urandom_range(0, 3));
    b.drain = 1'b0;
    b.gap = 0;
    return b;
  endfunction

  function automatic stick_beat_t board_beat(logic [1:0] v);
    stick_beat_t b;
    b = blank_beat(CMD_BOARD);
    b.board_in = v;
    return b;
  endfunction

  function automatic stick_beat_t stick(input logic signed [15:0] lh, lvr, rh, rvr,
                                        input logic west, south, input logic [31:0] ms);
    stick_beat_t b;
    b = blank_beat(CMD_JOY);
    b.lh = lh;
    b.lvr = lvr;
    b.rh = rh;
    b.rvr = rvr;
    b.west = west;
    b.south = south;
    b.ms = ms;
    return b;
  endfunction

  function automatic logic signed [15:0] quiet_axis();
    longint v;
    v = $urandom_range(0, thr_reg);
    return 16'($urandom_range(0, 1) ? -v : v);
  endfunction

  function automatic logic signed [15:0] loud_axis();
    longint v;
    v = $urandom_range(thr_reg + 1, 32768);
    return 16'($urandom_range(0, 1) ? -v : v);
  endfunction

  function automatic logic signed [15:0] any_axis();
    longint v;
    case ($urandom_range(0, 6))
      0: return quiet_axis();
      1: return loud_axis();
      2: begin
        v = thr_reg + $urandom_range(0, 1);
        return 16'($urandom_range(0, 1) ? -v : v);
      end
      3: return 16'sh7FFF;
      4: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] any_step();
    return $urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 300);
  endfunction

  function automatic stick_beat_t joy_beat(drive_kind_t how, logic [31:0] step);
    stick_beat_t b;
    ms_now = ms_now + step;
    b = blank_beat(CMD_JOY);
    b.west = $urandom_range(0, 1);
    b.south = $urandom_range(0, 1);
    case (how)
      DRIVE_MIX: begin
        b.lh = any_axis();
        b.lvr = any_axis();
        b.rh = any_axis();
        b.rvr = any_axis();
        if ($urandom_range(0, 1)) b.lh = loud_axis();
        else b.lvr = loud_axis();
      end
      DRIVE_TURN: begin
        b.lh = quiet_axis();
        b.lvr = quiet_axis();
        b.rh = loud_axis();
        b.rvr = any_axis();
      end
      DRIVE_RISE: begin
        b.lh = quiet_axis();
        b.lvr = quiet_axis();
        b.rh = quiet_axis();
        b.rvr = loud_axis();
      end
      DRIVE_REST: begin
        b.lh = quiet_axis();
        b.lvr = quiet_axis();
        b.rh = quiet_axis();
        b.rvr = quiet_axis();
      end
      default: begin
        b.lh = any_axis();
        b.lvr = any_axis();
        b.rh = any_axis();
        b.rvr = any_axis();
      end
    endcase
    return b;
  endfunction

  function automatic void push_item(stick_beat_t b);
    if (beats_made % 40 == 0) begin
      tx_calm = $urandom_range(0, 3) == 0;
      rx_calm = $urandom_range(0, 3) == 0;
    end
    b.gap = tx_calm ? 0 : $urandom_range(0, 16);
    b.drain = beats_made % 50 == 7;
    pending.push_back(b);
    if (b.cmd != CMD_NONE) beats_made++;
  endfunction

  task automatic run_directed();
    push_item(blank_beat(CMD_HEALTH));
    push_item(board_beat(BOARD_RUN));
    push_item(board_beat(BOARD_RESERVED));
    push_item(blank_beat(CMD_HEALTH));
    push_item(stick(0, 0, 0, 0, 1'b1, 1'b1, 10));
    push_item(stick(0, 0, 0, 0, 1'b0, 1'b1, 20));
    push_item(stick(16'sh7FFF, 16'sh8000, 0, 0, 1'b0, 1'b0, 30));
    push_item(stick(16'sh8000, 16'sh7FFF, 0, 0, 1'b1, 1'b0, 40));
    push_item(stick(3277, -3278, 0, 0, 1'b0, 1'b0, 50));
    push_item(stick(-3277, 3277, 3277, -3277, 1'b0, 1'b0, 55));
    push_item(stick(20000, 0, 0, 0, 1'b0, 1'b0, 60));
    push_item(stick(0, 0, 16'sh7FFF, 0, 1'b0, 1'b0, 70));
    push_item(stick(0, 0, 16'sh8000, 0, 1'b0, 1'b0, 80));
    push_item(stick(0, 0, 3278, 16'sh8000, 1'b0, 1'b0, 90));
    push_item(blank_beat(CMD_HEALTH));
    // The hold starts at 1000 ms; exactly the delay later the thrusters still rest.
    push_item(stick(0, 0, 0, 16'sh8000, 1'b0, 1'b0, 1000));
    push_item(stick(0, 0, 0, 16'sh8000, 1'b0, 1'b0, 1500));
    push_item(stick(0, 0, 0, 16'sh8000, 1'b0, 1'b0, 1501));
    push_item(stick(0, 0, 0, 16'sh7FFF, 1'b0, 1'b0, 2000));
    push_item(stick(0, 0, 0, 0, 1'b0, 1'b0, 2001));
    push_item(stick(0, 0, 0, 20000, 1'b0, 1'b0, 32'hFFFF_FF00));
    push_item(stick(0, 0, 0, 20000, 1'b0, 1'b0, 32'h0000_0200));
    push_item(board_beat(BOARD_INIT));
    push_item(blank_beat(CMD_NONE));
    push_item(blank_beat(CMD_HEALTH));
    push_item(board_beat(BOARD_SUSPEND));
  endtask

  task automatic fill_random(int goal);
    int pick;
    int run;
    bit exact;
    logic [31:0] step;
    goal += beats_made;
    while (beats_made < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        push_item(joy_beat(DRIVE_MIX, any_step()));
      end else if (pick < 32) begin
        push_item(joy_beat(DRIVE_TURN, any_step()));
      end else if (pick < 40) begin
        push_item(joy_beat(DRIVE_REST, any_step()));
      end else if (pick < 50) begin
        push_item(joy_beat(DRIVE_ANY, any_step()));
      end else if (pick < 72) begin
        run = $urandom_range(2, 8);
        exact = $urandom_range(0, 2) == 0;
        for (int k = 0; k < run; k++) begin
          if (k == 0) step = any_step();
          else if (exact && k == 1) step = delay_reg;
          else if (exact && k == 2) step = 1;
          else step = $urandom_range(0, delay_reg / 2 + 20);
          push_item(joy_beat(DRIVE_RISE, step));
          if ($urandom_range(0, 5) == 0) push_item(blank_beat(CMD_HEALTH));
        end
      end else if (pick < 86) begin
        push_item(blank_beat(CMD_HEALTH));
      end else if (pick < 95) begin
        push_item(board_beat(2'($urandom_range(0, 3))));
      end else begin
        push_item(blank_beat(CMD_NONE));
      end
    end
  endtask

  task automatic settle();
    while (pending.size() != 0 || sample_valid || due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_THRESHOLD: thr_reg = data[14:0];
      CFG_GAIN: gain_reg = data[14:0];
      CFG_DELAY: delay_reg = data;
      default: eps_reg = data[14:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(longint thr, longint gain, longint delay, longint eps);
    write_reg(CFG_THRESHOLD, {1'($urandom), 15'(thr)});
    write_reg(CFG_GAIN, {1'($urandom), 15'(gain)});
    write_reg(CFG_DELAY, 16'(delay));
    write_reg(CFG_EPSILON, {1'($urandom), 15'(eps)});
  endtask

  always @(negedge clk) begin : feed
    if (!rst && (!sample_valid || samples_taken == samples_sent)) begin
      if (!gap_armed && pending.size() != 0) begin
        gap_left = pending[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_armed && gap_left == 0 && !(pending[0].drain && due.size() != 0)) begin
        cur = pending.pop_front();
        gap_armed = 1'b0;
        samples_sent++;
        sample_valid <= 1'b1;
        cmd <= cur.cmd;
        left_horizontal <= cur.lh;
        left_vertical_raw <= cur.lvr;
        right_horizontal <= cur.rh;
        right_vertical_raw <= cur.rvr;
        button_west <= cur.west;
        button_south <= cur.south;
        time_ms <= cur.ms;
        board_state_in <= cur.board_in;
      end else begin
        if (gap_left != 0) gap_left--;
        sample_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : take
    if (outputs_taken != outputs_seen) begin
      outputs_seen = outputs_taken;
      stall_left = rx_calm ? 0 : $urandom_range(0, 16);
    end
    result_stall <= stall_left != 0;
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin : watch
    mixer_out_t want;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        samples_taken++;
        if (predict_mixer_output(cur, want)) due.push_back(want);
      end
      if (result_valid && !result_stall) begin
        outputs_taken++;
        if (due.size() == 0) begin
          errors++;
          if (errors <= 100) begin
            $display("%0t ns: expected no beat, got kind %0d thrusters %0d %0d %0d %0d",
                     $time, result_kind, thruster_a, thruster_b, thruster_c, thruster_d);
          end
        end else begin
          want = due.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("thruster_a", want.pa, thruster_a);
          check_field("thruster_b", want.pb, thruster_b);
          check_field("thruster_c", want.pc, thruster_c);
          check_field("thruster_d", want.pd, thruster_d);
          check_field("servo_code", want.servo, servo_code);
          check_field("order_initialize", want.init_order, order_initialize);
          check_field("order_suspend", want.suspend_order, order_suspend);
          check_field("led_left", want.led_l, led_left);
          check_field("led_right", want.led_r, led_right);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    fill_random(190);
    settle();
    set_regs(0, 32767, 0, 0);
    ms_now = 32'hFFFF_F000;
    fill_random(190);
    settle();
    set_regs(32767, 0, 65535, 32767);
    fill_random(190);
    settle();
    set_regs(16, 1, 3, 1);
    fill_random(190);
    settle();
    repeat (2) begin
      set_regs($urandom_range(0, 8000), $urandom_range(0, 32767),
               $urandom_range(0, 2000), $urandom_range(0, 2000));
      ms_now = $urandom;
      fill_random(190);
      settle();
    end
    if (errors == 0 && due.size() == 0) begin
      $display("joystick_thruster_mixer test passed");
    end else begin
      $display("joystick_thruster_mixer test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("joystick_thruster_mixer test failed");
    $finish;
  end

endmodule
